// ===== design/inverse_park_svpwm_timing_top_assert.svh =====
// Assertion macros for the inverse Park / SVPWM timing block
`ifndef INVERSE_PARK_SVPWM_TIMING_TOP_ASSERT_SVH
`define INVERSE_PARK_SVPWM_TIMING_TOP_ASSERT_SVH
// implication checked on every clock, idle in reset
`define IPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
// plain invariant
`define IPS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant failed");
`endif

// ===== design/ips_pkg.sv =====
// Package: types, constants and tables of the inverse Park / SVPWM timing block
`timescale 1ns / 1ps
`default_nettype none
package ips_pkg;
	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int CW            = 28;	// cordic x/y width
	localparam int ZW            = 33;	// angle accumulator width
	localparam int NW            = 48;	// divider numerator and quotient width
	localparam int DW            = 31;	// divider denominator width
	localparam int SW            = 20;	// side data carried along the divider

	localparam logic [1:0] REG_BUS    = 2'd0;
	localparam logic [1:0] REG_PERIOD = 2'd1;

	localparam logic [2:0] SEC_1 = 3'd1, SEC_2 = 3'd2, SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4, SEC_5 = 3'd5, SEC_6 = 3'd6;

	typedef struct packed {
		logic signed [15:0] voltage_d;
		logic signed [15:0] voltage_q;
		logic        [15:0] rotor_angle;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  sector_code;
		logic [15:0] time_a;
		logic [15:0] time_b;
		logic [15:0] time_c;
	} out_word_t;

	typedef struct packed {
		logic                  vld;
		logic signed [CW-1:0]  x;
		logic signed [CW-1:0]  y;
		logic signed [ZW-1:0]  z;
	} cord_t;

	function automatic logic signed [ZW-1:0] atan_turn(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
			3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
			9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
			default: t = 32'h0;
		endcase
		return $signed({1'b0, t});
	endfunction
endpackage
`default_nettype wire

// ===== design/inverse_park_svpwm_timing_top.sv =====
// Top level: inverse Park rotation and seven-segment SVPWM compare times
// Throughput: one word per cycle; the whole datapath is a chain of cells that
// advances together whenever the output register can take the word ahead.
// Reset: arst_n clears valid flags; bus_voltage returns to 32767, pwm_period to 5000.
`timescale 1ns / 1ps
`default_nettype none
module inverse_park_svpwm_timing_top import ips_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  wire        out_ready,
	output out_word_t  out_data,
	input  wire        cfg_we,
	input  wire  [1:0] cfg_index,
	input  wire  [15:0] cfg_data
);
	localparam int DLAT = NW;

	logic [14:0] bus_q;
	logic [15:0] per_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q <= 15'd32767;
			per_q <= 16'd5000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BUS:    bus_q <= cfg_data[14:0];
				REG_PERIOD: per_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// whole chain stalls only when the output holds an unread word
	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// pre-rotation into +-90 degrees
	cord_t c [CORDIC_STAGES+1];
	logic [ZW-1:0] z0;
	logic signed [CW-1:0] x0, y0;
	logic flip;
	always_comb begin
		z0 = {{(ZW-32){1'b0}}, ({in_data.rotor_angle, 16'd0}
			& ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1))};
		if (z0[31]) z0 = z0 - (33'd1 << 32);
		flip = 1'b0;
		if ($signed(z0) > $signed(33'd1 << 30)) begin
			z0 = z0 - (33'd1 << 31); flip = 1'b1;
		end else if ($signed(z0) < -$signed(33'd1 << 30)) begin
			z0 = z0 + (33'd1 << 31); flip = 1'b1;
		end
		x0 = CW'(in_data.voltage_d) <<< 8;
		y0 = CW'(in_data.voltage_q) <<< 8;
		if (flip) begin x0 = -x0; y0 = -y0; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c[0] <= '0;
		end else if (en) begin
			c[0].vld <= in_valid;
			c[0].x <= x0;
			c[0].y <= y0;
			c[0].z <= z0;
		end
	end

	for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cord
		ips_cordic_cell u_cell (.clk(clk), .arst_n(arst_n), .en(en),
			.shift(5'(s)), .step(atan_turn(s)), .d(c[s]), .q(c[s+1]));
	end

	// gain removal
	logic vld_s1;
	logic signed [CW+15:0] ax_s1, by_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0; else if (en) vld_s1 <= c[CORDIC_STAGES].vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= (CW+16)'(c[CORDIC_STAGES].x) * (CW+16)'(19898) + (CW+16)'(1 << 22);
			by_s1 <= (CW+16)'(c[CORDIC_STAGES].y) * (CW+16)'(19898) + (CW+16)'(1 << 22);
		end
	end
	logic signed [20:0] al, be;
	assign al = 21'(ax_s1 >>> 23);
	assign be = 21'(by_s1 >>> 23);

	// sector and X/Y/Z numerators
	logic vld_s2;
	logic [2:0] code_s2;
	logic signed [39:0] nx_s2, ny_s2, nz_s2;
	logic signed [39:0] ps3, pb, ph, p15;
	always_comb begin
		ps3 = 40'(al) * 40'sd56756;
		pb  = 40'(be) * 40'sd32768;
		ph  = 40'(be) * 40'sd28378;
		p15 = 40'(al) * 40'sd49152;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0; else if (en) vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			code_s2 <= {(-ps3 - pb) > 0, (ps3 - pb) > 0, be > 0};
			nx_s2 <= 40'(be) * 40'sd56756;
			ny_s2 <= ph + p15;
			nz_s2 <= ph - p15;
		end
	end

	// choose T1/T2 numerators with sign, then scale by T
	logic vld_s3;
	logic [2:0] code_s3;
	logic signed [39:0] n1_s3, n2_s3;
	logic signed [39:0] n1, n2;
	always_comb begin
		case (code_s2)
			SEC_1: begin n1 = nz_s2;  n2 = ny_s2;  end
			SEC_2: begin n1 = ny_s2;  n2 = -nx_s2; end
			SEC_3: begin n1 = -nz_s2; n2 = nx_s2;  end
			SEC_4: begin n1 = -nx_s2; n2 = nz_s2;  end
			SEC_5: begin n1 = nx_s2;  n2 = -ny_s2; end
			SEC_6: begin n1 = -ny_s2; n2 = -nz_s2; end
			default: begin n1 = '0; n2 = '0; end
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0; else if (en) vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			code_s3 <= code_s2;
			n1_s3 <= n1[39] ? '0 : n1;	// negative terms floor to zero
			n2_s3 <= n2[39] ? '0 : n2;
		end
	end

	logic vld_s4;
	logic [2:0] code_s4;
	logic [NW-1:0] p1_s4, p2_s4;
	logic [DW-1:0] den_s4;
	logic [15:0] per_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0; else if (en) vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			code_s4 <= code_s3;
			p1_s4 <= NW'(n1_s3[38:0]) * NW'(per_q);
			p2_s4 <= NW'(n2_s3[38:0]) * NW'(per_q);
			den_s4 <= {(bus_q == 15'd0) ? 15'd1 : bus_q, 16'd0} >> 1;
			per_s4 <= per_q;
		end
	end

	logic [NW-1:0] q1, q2;
	logic [SW-1:0] sd1, sd2;
	logic [SW-1:0] side_in;
	assign side_in = {vld_s4, code_s4, per_s4};
	ips_divider u_div1 (.clk(clk), .en(en),
		.num(p1_s4), .den(den_s4), .side(side_in), .quo(q1), .side_out(sd1));
	ips_divider u_div2 (.clk(clk), .en(en),
		.num(p2_s4), .den(den_s4), .side(side_in), .quo(q2), .side_out(sd2));

	// divider payload valid is tracked in reset-cleared flops alongside
	logic [DLAT-1:0] dv_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_q <= '0;
		else if (en) dv_q <= {dv_q[DLAT-2:0], vld_s4};
	end

	// compare times
	logic signed [NW+1:0] rem, ta, tb, tc, tp;
	always_comb begin
		tp = (NW+2)'(sd1[15:0]);
		rem = tp - (NW+2)'(q1) - (NW+2)'(q2);
		ta = (rem > 0) ? (rem >>> 2) : '0;
		tb = ta + (NW+2)'(q1 >> 1);
		if (tb > tp) tb = tp;
		tc = tb + (NW+2)'(q2 >> 1);
		if (tc > tp) tc = tp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_q[DLAT-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_data.sector_code <= sd1[18:16];
			out_data.time_a <= ta[15:0];
			out_data.time_b <= tb[15:0];
			out_data.time_c <= tc[15:0];
		end
	end

	logic unused;
	assign unused = ^{sd1[19], sd2};
endmodule
`default_nettype wire

// ===== design/ips_cordic_cell.sv =====
// One CORDIC rotation cell: shift and atan step tied off by its place in the row, registered
`timescale 1ns / 1ps
`default_nettype none
module ips_cordic_cell import ips_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire  [4:0]           shift,
	input  wire  signed [ZW-1:0] step,
	input  cord_t                d,
	output cord_t                q
);
	logic signed [CW-1:0] dx, dy;
	assign dx = d.y >>> shift;
	assign dy = d.x >>> shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.vld <= d.vld;
			if (!d.z[ZW-1]) begin
				q.x <= d.x - dx;
				q.y <= d.y + dy;
				q.z <= d.z - step;
			end else begin
				q.x <= d.x + dx;
				q.y <= d.y - dy;
				q.z <= d.z + step;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/ips_divider.sv =====
// Restoring divider cell row: one quotient bit per cell, divisor and side data carried
`timescale 1ns / 1ps
`default_nettype none
module ips_divider import ips_pkg::*; (
	input  wire           clk,
	input  wire           en,
	input  wire  [NW-1:0] num,
	input  wire  [DW-1:0] den,
	input  wire  [SW-1:0] side,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic [NW-1:0] r_q   [NW+1];
	logic [NW-1:0] qb_q  [NW+1];
	logic [DW-1:0] d_q   [NW+1];
	logic [SW-1:0] s_q   [NW+1];

	always_comb begin
		r_q[0] = num;
		qb_q[0] = '0;
		d_q[0] = den;
		s_q[0] = side;
	end

	for (genvar k = 0; k < NW; k++) begin : g_cell
		localparam int B = NW - 1 - k;
		logic [NW+DW-1:0] sh;
		logic             ge;
		assign sh = {{DW{1'b0}}, d_q[k]} << B;
		assign ge = {{DW{1'b0}}, r_q[k]} >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k+1]  <= ge ? r_q[k] - sh[NW-1:0] : r_q[k];
				qb_q[k+1] <= qb_q[k] | (NW'(ge) << B);
				d_q[k+1]  <= d_q[k];
				s_q[k+1]  <= s_q[k];
			end
		end
	end
	assign quo = qb_q[NW];
	assign side_out = s_q[NW];
endmodule
`default_nettype wire

// ===== design/ips_checker.sv =====
// Port-level checker for the inverse Park / SVPWM timing block
`timescale 1ns / 1ps
`default_nettype none
`include "inverse_park_svpwm_timing_top_assert.svh"
module ips_checker import ips_pkg::*; (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input out_word_t out_data
);
	logic stall, ordered;
	assign stall = out_valid && !out_ready;
	assign ordered = out_data.time_a <= out_data.time_b
		&& out_data.time_b <= out_data.time_c;

	`IPS_ASSERT_IMPL(a_stall_hold, clk, arst_n, stall, ##1 out_valid && $stable(out_data))
	`IPS_ASSERT_IMPL(a_ready_free, clk, arst_n, !out_valid, in_ready)
	`IPS_ASSERT_IMPL(a_ready_stall, clk, arst_n, stall, !in_ready)
	`IPS_ASSERT_IMPL(a_in_hold, clk, arst_n, in_valid && !in_ready, ##1 in_valid)
	`IPS_ASSERT_ALWAYS(a_order, clk, arst_n, !out_valid || ordered)
endmodule
bind inverse_park_svpwm_timing_top ips_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .out_data(out_data));
`default_nettype wire

// ===== bench/inverse_park_svpwm_timing_checker.sv =====
// Checker: predicts sector code and compare times for each accepted word and compares them
`timescale 1ns / 1ps
`default_nettype none
module inverse_park_svpwm_timing_checker import ips_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_ready,
	input  in_word_t   in_data,
	input  wire        out_valid,
	input  wire        out_ready,
	input  out_word_t  out_data,
	input  wire        cfg_we,
	input  wire  [1:0] cfg_index,
	input  wire  [15:0] cfg_data,
	output int         fails,
	output int         pending
);
	localparam longint ARCTAN [0:15] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

	logic [14:0] bus_v;
	logic [15:0] period;
	out_word_t   timing_q[$];

	function automatic longint scaled(longint num, longint t, longint vb);
		return (num * t) / (vb * 32768);	// truncates toward zero
	endfunction

	function automatic out_word_t svpwm_times(in_word_t w);
		longint x, y, z, dx, dy, al, be, tp, vb, xx, yy, zz, t1, t2, rem, ta, tb, tc;
		logic [2:0] n;
		out_word_t r;
		x = longint'(w.voltage_d) * 256;
		y = longint'(w.voltage_q) * 256;
		z = longint'({w.rotor_angle, 16'h0000});
		if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
		if (z > 64'sd1073741824) begin
			z = z - 64'sd2147483648; x = -x; y = -y;
		end else if (z < -64'sd1073741824) begin
			z = z + 64'sd2147483648; x = -x; y = -y;
		end
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - ARCTAN[i];
			end else begin
				x = x + dx; y = y - dy; z = z + ARCTAN[i];
			end
		end
		al = (x * 19898 + (64'sd1 <<< 22)) >>> 23;
		be = (y * 19898 + (64'sd1 <<< 22)) >>> 23;
		n[0] = be > 0;
		n[1] = (al * 56756 - be * 32768) > 0;
		n[2] = (-al * 56756 - be * 32768) > 0;
		tp = longint'(period);
		vb = (bus_v == 0) ? 1 : longint'(bus_v);
		xx = scaled(be * 56756, tp, vb);
		yy = scaled(be * 28378 + al * 49152, tp, vb);
		zz = scaled(be * 28378 - al * 49152, tp, vb);
		case (n)
			SEC_1: begin t1 = zz;  t2 = yy;  end
			SEC_2: begin t1 = yy;  t2 = -xx; end
			SEC_3: begin t1 = -zz; t2 = xx;  end
			SEC_4: begin t1 = -xx; t2 = zz;  end
			SEC_5: begin t1 = xx;  t2 = -yy; end
			SEC_6: begin t1 = -yy; t2 = -zz; end
			default: begin t1 = 0; t2 = 0; end	// zero vector
		endcase
		if (t1 < 0) t1 = 0;
		if (t2 < 0) t2 = 0;
		rem = tp - t1 - t2;
		ta = (rem > 0) ? rem / 4 : 0;
		tb = ta + t1 / 2;
		if (tb > tp) tb = tp;
		tc = tb + t2 / 2;
		if (tc > tp) tc = tp;
		r.sector_code = n;
		r.time_a = ta[15:0];
		r.time_b = tb[15:0];
		r.time_c = tc[15:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			bus_v = 15'd32767;
			period = 16'd5000;
			timing_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_BUS) bus_v = cfg_data[14:0];
				else if (cfg_index == REG_PERIOD) period = cfg_data;
			end
			if (in_valid && in_ready) timing_q.push_back(svpwm_times(in_data));
			if (out_valid && out_ready) begin
				if (timing_q.size() == 0) begin
					$error("unexpected word: sector %0d", out_data.sector_code);
					fails++;
				end else begin
					e = timing_q.pop_front();
					if (e.sector_code !== out_data.sector_code) begin
						$error("sector_code exp %0d got %0d", e.sector_code,
							out_data.sector_code);
						fails++;
					end
					if (e.time_a !== out_data.time_a) begin
						$error("time_a exp %0d got %0d", e.time_a, out_data.time_a);
						fails++;
					end
					if (e.time_b !== out_data.time_b) begin
						$error("time_b exp %0d got %0d", e.time_b, out_data.time_b);
						fails++;
					end
					if (e.time_c !== out_data.time_c) begin
						$error("time_c exp %0d got %0d", e.time_c, out_data.time_c);
						fails++;
					end
				end
			end
			pending = timing_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== bench/inverse_park_svpwm_timing_top_tb.sv =====
// Testbench top: clock, reset, stimulus, register phases and the verdict
`timescale 1ns / 1ps
`default_nettype none
module inverse_park_svpwm_timing_top_tb import ips_pkg::*;;

	localparam logic [1:0] REG_SPARE = 2'd3;	// no register behind this index
	localparam int DRAIN = 100;	// a little over the pipeline depth

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_word_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_word_t  out_data;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int         fails, pending;
	int         words_sent = 0;
	bit         burst = 1'b0;	// no idling on either side while set
	bit         done = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	inverse_park_svpwm_timing_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	inverse_park_svpwm_timing_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// valid held high across back-to-back words; dropped only for a real gap
	task automatic send(input in_word_t w);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		in_data = w;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_word(input int d, input int q, input int ang);
		in_word_t w;
		w.voltage_d = d[15:0];
		w.voltage_q = q[15:0];
		w.rotor_angle = ang[15:0];
		send(w);
	endtask

	// registers only change with the pipeline empty
	task automatic set_regs(input int bus, input int per);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = REG_BUS;
		cfg_data = bus[15:0];
		@(negedge clk);
		cfg_index = REG_PERIOD;
		cfg_data = per[15:0];
		@(negedge clk);
		cfg_index = REG_SPARE;	// must be ignored
		cfg_data = 16'($urandom);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// random word: full range, small vectors, or near-axis angles
	task automatic send_random();
		int r, d, q, a;
		r = $urandom_range(0, 9);
		a = $urandom_range(0, 65535);
		if (r < 4) begin
			d = $urandom_range(0, 65535);
			q = $urandom_range(0, 65535);
		end else if (r < 8) begin
			d = $urandom_range(0, 8000) - 4000;
			q = $urandom_range(0, 8000) - 4000;
		end else begin
			d = $urandom_range(0, 65535);
			q = $urandom_range(0, 65535);
			a = (16384 * $urandom_range(0, 3) + $urandom_range(0, 4) - 2) & 16'hFFFF;
		end
		send_word(d, q, a);
	endtask

	// receiver: random stalls, and one long hold-off so the pipe backs up
	initial begin : receiver
		int g;
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && words_sent >= 200) begin
				held = 1'b1;
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
			end
			g = gap_len();
			if (g > 0) begin
				out_ready = 1'b0;
				repeat (g - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	initial begin : stimulus
		int bus, per;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words at reset values: axes, boundaries, extremes, zero vector
		send_word(0, 0, 0);
		send_word(32767, 0, 0);
		send_word(-32768, 0, 0);
		send_word(0, 32767, 0);
		send_word(0, -32768, 16384);
		send_word(32767, 32767, 16384);
		send_word(-32768, -32768, 32768);
		send_word(20000, -5000, 49152);
		send_word(20000, 5000, 16385);
		send_word(-20000, 5000, 49151);
		send_word(1000, 2000, 65535);
		send_word(32767, -32768, 32767);
		send_word(3000, 0, 10923);
		send_word(3000, 0, 21845);
		send_word(16'hAAAA, 16'h5555, 16'hAAAA);
		send_word(16'h5555, 16'hAAAA, 16'h5555);

		// overmodulation: tiny bus, long period
		set_regs(1, 65535);
		send_word(32767, 32767, 4000);
		send_word(-300, 100, 40000);
		// zero bus treated as one, zero period
		set_regs(0, 0);
		send_word(12000, -7000, 30000);
		set_regs(32767, 1);
		send_word(32767, 0, 8000);

		// random phases, one in burst mode
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin bus = 32767; per = 65535; end
				1: begin bus = 1; per = 5000; end
				default: begin
					bus = $urandom_range(1, 32767);
					per = $urandom_range(1, 65535);
				end
			endcase
			set_regs(bus, per);
			burst = (ph == 3);
			for (int k = 0; k < 150; k++) send_random();
			burst = 1'b0;
		end

		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		done = 1'b1;
	end

	initial begin : verdict
		wait (done);
		if (fails == 0)
			$display("inverse_park_svpwm_timing_top: match");
		else
			$display("inverse_park_svpwm_timing_top: mismatch");
		$finish;
	end

	initial begin : watchdog
		#20ms;
		$display("inverse_park_svpwm_timing_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/ips_pkg.sv
design/ips_cordic_cell.sv
design/ips_divider.sv
design/inverse_park_svpwm_timing_top.sv
design/ips_checker.sv
bench/inverse_park_svpwm_timing_checker.sv
bench/inverse_park_svpwm_timing_top_tb.sv
